>>> hdl/sexpr_token_lexer_unit_defines.svh
// Assertion macros for the S-expression token lexer.
// Included by the top level; depends on nothing else.
`ifndef SEXPR_TOKEN_LEXER_UNIT_DEFINES_SVH
`define SEXPR_TOKEN_LEXER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define SXL_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sexpr token lexer check failed");

// Next-cycle implication, disabled during reset.
`define SXL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sexpr token lexer check failed");

`endif

>>> hdl/sxl_pkg.sv
// Shared types and constants of the S-expression token lexer.
// Used by the front end, the job queue, the back end and the top level.
package sxl_pkg;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam logic [30:0] INT_CAP = 31'h7FFF_FFFF;

    localparam logic [7:0] CH_LPAREN    = 8'h28;
    localparam logic [7:0] CH_RPAREN    = 8'h29;
    localparam logic [7:0] CH_DOT       = 8'h2E;
    localparam logic [7:0] CH_HASH      = 8'h23;
    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_ZERO      = 8'h30;
    localparam logic [7:0] CH_NINE      = 8'h39;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_CR        = 8'h0D;

    localparam logic [2:0] K_IDENT = 3'd0;
    localparam logic [2:0] K_INT   = 3'd1;
    localparam logic [2:0] K_DBL   = 3'd2;
    localparam logic [2:0] K_STR   = 3'd3;
    localparam logic [2:0] K_CHR   = 3'd4;
    localparam logic [2:0] K_LPAR  = 3'd5;
    localparam logic [2:0] K_RPAR  = 3'd6;

    localparam logic [1:0] E_NONE    = 2'd0;
    localparam logic [1:0] E_BADHASH = 2'd1;
    localparam logic [1:0] E_UNTERM  = 2'd2;

    typedef enum logic [2:0] {
        M_IDLE,
        M_IDENT,
        M_INT,
        M_DBL,
        M_STR,
        M_HASH,
        M_CHR
    } mode_t;

    typedef struct packed {
        logic        text_valid;
        logic [7:0]  text_byte;
        logic        token_done;
        logic [2:0]  token_kind;
        logic [30:0] integer_value;
        logic [1:0]  error_code;
        logic        has_paren;
        logic [2:0]  paren_kind;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    typedef struct packed {
        logic paren_pending;
    } back_status_t;

endpackage

>>> hdl/sxl_front.sv
// Front end: accepts input bytes, runs the lexer mode and integer accumulator,
// and pushes one job per input that causes results. Depends on sxl_pkg.
module sxl_front
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [7:0]        next_byte,
    input  logic              end_of_stream,
    input  sxl_pkg::q_status_t q_status,
    output logic              push,
    output sxl_pkg::job_t     push_job
);

    sxl_pkg::mode_t mode_reg;
    sxl_pkg::mode_t mode_next;
    logic [30:0]    acc_reg;
    logic [30:0]    acc_next;

    logic        accept;
    logic        is_ws;
    logic        is_digit;
    logic        paren;
    logic [2:0]  pkind;
    logic [3:0]  digit;
    logic [34:0] acc_x10;
    logic [34:0] acc_sum;
    logic [30:0] acc_sat;

    assign in_stall = q_status.full;
    assign accept   = in_valid && !q_status.full;

    assign is_ws    = (next_byte == sxl_pkg::CH_SPACE) ||
                      ((next_byte >= sxl_pkg::CH_TAB) && (next_byte <= sxl_pkg::CH_CR));
    assign is_digit = (next_byte >= sxl_pkg::CH_ZERO) && (next_byte <= sxl_pkg::CH_NINE);
    assign paren    = (next_byte == sxl_pkg::CH_LPAREN) || (next_byte == sxl_pkg::CH_RPAREN);
    assign pkind    = (next_byte == sxl_pkg::CH_LPAREN) ? sxl_pkg::K_LPAR : sxl_pkg::K_RPAR;
    assign digit    = 4'(next_byte - sxl_pkg::CH_ZERO);

    assign acc_x10 = {1'b0, acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0};
    assign acc_sum = acc_x10 + {31'd0, digit};
    assign acc_sat = (acc_sum > {4'd0, sxl_pkg::INT_CAP}) ? sxl_pkg::INT_CAP : acc_sum[30:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= sxl_pkg::M_IDLE;
            acc_reg  <= '0;
        end
        else
        begin
            mode_reg <= mode_next;
            acc_reg  <= acc_next;
        end
    end

    always_comb
    begin
        mode_next = mode_reg;
        acc_next  = acc_reg;
        push      = 1'b0;
        push_job  = '0;
        if (accept)
        begin
            if (end_of_stream)
            begin
                case (mode_reg)
                    sxl_pkg::M_IDENT, sxl_pkg::M_INT, sxl_pkg::M_DBL:
                    begin
                        push                = 1'b1;
                        push_job.token_done = 1'b1;
                        if (mode_reg == sxl_pkg::M_INT)
                        begin
                            push_job.token_kind    = sxl_pkg::K_INT;
                            push_job.integer_value = acc_reg;
                        end
                        else if (mode_reg == sxl_pkg::M_DBL)
                        begin
                            push_job.token_kind = sxl_pkg::K_DBL;
                        end
                        else
                        begin
                            push_job.token_kind = sxl_pkg::K_IDENT;
                        end
                    end
                    sxl_pkg::M_STR, sxl_pkg::M_HASH, sxl_pkg::M_CHR:
                    begin
                        push                = 1'b1;
                        push_job.error_code = sxl_pkg::E_UNTERM;
                    end
                    default:
                    begin
                    end
                endcase
                mode_next = sxl_pkg::M_IDLE;
                acc_next  = '0;
            end
            else
            begin
                case (mode_reg)
                    sxl_pkg::M_IDLE:
                    begin
                        if (paren)
                        begin
                            push                = 1'b1;
                            push_job.token_done = 1'b1;
                            push_job.token_kind = pkind;
                        end
                        else if (is_ws)
                        begin
                        end
                        else if (is_digit)
                        begin
                            push                = 1'b1;
                            push_job.text_valid = 1'b1;
                            push_job.text_byte  = next_byte;
                            acc_next            = {27'd0, digit};
                            mode_next           = sxl_pkg::M_INT;
                        end
                        else if (next_byte == sxl_pkg::CH_QUOTE)
                        begin
                            mode_next = sxl_pkg::M_STR;
                        end
                        else if (next_byte == sxl_pkg::CH_HASH)
                        begin
                            mode_next = sxl_pkg::M_HASH;
                        end
                        else
                        begin
                            push                = 1'b1;
                            push_job.text_valid = 1'b1;
                            push_job.text_byte  = next_byte;
                            mode_next           = sxl_pkg::M_IDENT;
                        end
                    end
                    sxl_pkg::M_IDENT, sxl_pkg::M_INT, sxl_pkg::M_DBL:
                    begin
                        push = 1'b1;
                        if (is_ws || paren)
                        begin
                            push_job.token_done = 1'b1;
                            if (mode_reg == sxl_pkg::M_INT)
                            begin
                                push_job.token_kind    = sxl_pkg::K_INT;
                                push_job.integer_value = acc_reg;
                            end
                            else if (mode_reg == sxl_pkg::M_DBL)
                            begin
                                push_job.token_kind = sxl_pkg::K_DBL;
                            end
                            else
                            begin
                                push_job.token_kind = sxl_pkg::K_IDENT;
                            end
                            push_job.has_paren  = paren;
                            push_job.paren_kind = pkind;
                            mode_next           = sxl_pkg::M_IDLE;
                            acc_next            = '0;
                        end
                        else
                        begin
                            push_job.text_valid = 1'b1;
                            push_job.text_byte  = next_byte;
                            if ((mode_reg == sxl_pkg::M_INT) && is_digit)
                            begin
                                acc_next = acc_sat;
                            end
                            else if ((mode_reg == sxl_pkg::M_INT) &&
                                     (next_byte == sxl_pkg::CH_DOT))
                            begin
                                mode_next = sxl_pkg::M_DBL;
                                acc_next  = '0;
                            end
                            else if ((mode_reg == sxl_pkg::M_DBL) && is_digit)
                            begin
                            end
                            else
                            begin
                                mode_next = sxl_pkg::M_IDENT;
                                acc_next  = '0;
                            end
                        end
                    end
                    sxl_pkg::M_STR:
                    begin
                        push = 1'b1;
                        if (next_byte == sxl_pkg::CH_QUOTE)
                        begin
                            push_job.token_done = 1'b1;
                            push_job.token_kind = sxl_pkg::K_STR;
                            mode_next           = sxl_pkg::M_IDLE;
                        end
                        else
                        begin
                            push_job.text_valid = 1'b1;
                            push_job.text_byte  = next_byte;
                        end
                    end
                    sxl_pkg::M_HASH:
                    begin
                        if (next_byte == sxl_pkg::CH_BACKSLASH)
                        begin
                            mode_next = sxl_pkg::M_CHR;
                        end
                        else
                        begin
                            push                = 1'b1;
                            push_job.error_code = sxl_pkg::E_BADHASH;
                            mode_next           = sxl_pkg::M_IDLE;
                        end
                    end
                    sxl_pkg::M_CHR:
                    begin
                        push                = 1'b1;
                        push_job.text_valid = 1'b1;
                        push_job.text_byte  = next_byte;
                        push_job.token_done = 1'b1;
                        push_job.token_kind = sxl_pkg::K_CHR;
                        mode_next           = sxl_pkg::M_IDLE;
                    end
                    default:
                    begin
                        mode_next = sxl_pkg::M_IDLE;
                        acc_next  = '0;
                    end
                endcase
            end
        end
    end

endmodule

>>> hdl/sxl_queue.sv
// Short job queue between the lexer front end and the result back end.
// Depends on sxl_pkg for the job type and depth.
module sxl_queue
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  sxl_pkg::job_t      push_job,
    input  logic               pop,
    output sxl_pkg::job_t      head_job,
    output sxl_pkg::q_status_t status
);

    sxl_pkg::job_t                 entry_reg [sxl_pkg::QDEPTH];
    logic [sxl_pkg::QPTR_W-1:0]    wr_ptr_reg;
    logic [sxl_pkg::QPTR_W-1:0]    rd_ptr_reg;
    logic [sxl_pkg::QCNT_W-1:0]    count_reg;
    logic [sxl_pkg::QCNT_W-1:0]    count_next;

    assign head_job     = entry_reg[rd_ptr_reg];
    assign status.full  = (count_reg == sxl_pkg::QCNT_W'(sxl_pkg::QDEPTH));
    assign status.empty = (count_reg == '0);

    always_comb
    begin
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

endmodule

>>> hdl/sxl_back.sv
// Back end: takes jobs from the queue and delivers their one or two results
// through an output register. Depends on sxl_pkg.
module sxl_back
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  sxl_pkg::job_t         head_job,
    input  sxl_pkg::q_status_t    q_status,
    output logic                  pop,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic                  text_valid,
    output logic [7:0]            text_byte,
    output logic                  token_done,
    output logic [2:0]            token_kind,
    output logic [30:0]           integer_value,
    output logic [1:0]            error_code,
    output logic                  last_of_run,
    output sxl_pkg::back_status_t status
);

    logic        valid_reg;
    logic        valid_next;
    logic        pend_reg;
    logic        pend_next;
    logic [2:0]  pkind_reg;
    logic [2:0]  pkind_next;
    logic        load;

    logic        tv_reg;
    logic        tv_next;
    logic [7:0]  tb_reg;
    logic [7:0]  tb_next;
    logic        done_reg;
    logic        done_next;
    logic [2:0]  kind_reg;
    logic [2:0]  kind_next;
    logic [30:0] ival_reg;
    logic [30:0] ival_next;
    logic [1:0]  err_reg;
    logic [1:0]  err_next;
    logic        last_reg;
    logic        last_next;

    assign load = !valid_reg || !out_stall;

    always_comb
    begin
        pop        = 1'b0;
        valid_next = valid_reg;
        pend_next  = pend_reg;
        pkind_next = pkind_reg;
        tv_next    = tv_reg;
        tb_next    = tb_reg;
        done_next  = done_reg;
        kind_next  = kind_reg;
        ival_next  = ival_reg;
        err_next   = err_reg;
        last_next  = last_reg;
        if (load)
        begin
            if (pend_reg)
            begin
                valid_next = 1'b1;
                pend_next  = 1'b0;
                tv_next    = 1'b0;
                tb_next    = '0;
                done_next  = 1'b1;
                kind_next  = pkind_reg;
                ival_next  = '0;
                err_next   = sxl_pkg::E_NONE;
                last_next  = 1'b1;
            end
            else if (!q_status.empty)
            begin
                pop        = 1'b1;
                valid_next = 1'b1;
                pend_next  = head_job.has_paren;
                pkind_next = head_job.paren_kind;
                tv_next    = head_job.text_valid;
                tb_next    = head_job.text_byte;
                done_next  = head_job.token_done;
                kind_next  = head_job.token_kind;
                ival_next  = head_job.integer_value;
                err_next   = head_job.error_code;
                last_next  = !head_job.has_paren;
            end
            else
            begin
                valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pkind_reg <= pkind_next;
        tv_reg    <= tv_next;
        tb_reg    <= tb_next;
        done_reg  <= done_next;
        kind_reg  <= kind_next;
        ival_reg  <= ival_next;
        err_reg   <= err_next;
        last_reg  <= last_next;
    end

    assign out_valid            = valid_reg;
    assign text_valid           = tv_reg;
    assign text_byte            = tb_reg;
    assign token_done           = done_reg;
    assign token_kind           = kind_reg;
    assign integer_value        = ival_reg;
    assign error_code           = err_reg;
    assign last_of_run          = last_reg;
    assign status.paren_pending = pend_reg;

endmodule

>>> hdl/sexpr_token_lexer_unit.sv
// Top level of the S-expression token lexer: front end, job queue, back end.
// Depends on sxl_pkg, sxl_front, sxl_queue, sxl_back and the defines header.
//
// Channel  | Handshake           | Payload
// ---------+---------------------+--------------------------------------------
// input    | in_valid, in_stall  | next_byte, end_of_stream
// output   | out_valid, out_stall| text_valid, text_byte, token_done,
//          |                     | token_kind, integer_value, error_code,
//          |                     | last_of_run
//
// One input byte is accepted every cycle while the four-entry job queue has room.
// The first result of an input passes through the job queue and then the output register.
// A paren that ends a pending token leaves the back end as a second result after the token.
// Reset is asynchronous, active low, and returns the lexer to idle with an empty queue.
// in_stall rises only when the job queue is full; out_stall holds the output register.
`include "sexpr_token_lexer_unit_defines.svh"

module sexpr_token_lexer_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  next_byte,
    input  logic        end_of_stream,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        text_valid,
    output logic [7:0]  text_byte,
    output logic        token_done,
    output logic [2:0]  token_kind,
    output logic [30:0] integer_value,
    output logic [1:0]  error_code,
    output logic        last_of_run
);

    logic                  push;
    sxl_pkg::job_t         push_job;
    logic                  pop;
    sxl_pkg::job_t         head_job;
    sxl_pkg::q_status_t    q_status;
    sxl_pkg::back_status_t back_status;

    sxl_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .next_byte     (next_byte),
        .end_of_stream (end_of_stream),
        .q_status      (q_status),
        .push          (push),
        .push_job      (push_job)
    );

    sxl_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .status   (q_status)
    );

    sxl_back u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .head_job      (head_job),
        .q_status      (q_status),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .text_valid    (text_valid),
        .text_byte     (text_byte),
        .token_done    (token_done),
        .token_kind    (token_kind),
        .integer_value (integer_value),
        .error_code    (error_code),
        .last_of_run   (last_of_run),
        .status        (back_status)
    );

    `SXL_ASSERT_NOW(a_pend_first, clk, rst_n, back_status.paren_pending,
        out_valid && !last_of_run)
    `SXL_ASSERT_NEXT(a_pend_paren, clk, rst_n, back_status.paren_pending && !out_stall,
        out_valid && token_done && last_of_run &&
        ((token_kind == sxl_pkg::K_LPAR) || (token_kind == sxl_pkg::K_RPAR)))
    `SXL_ASSERT_NOW(a_err_alone, clk, rst_n, out_valid && (error_code != sxl_pkg::E_NONE),
        !token_done && !text_valid && last_of_run)
    `SXL_ASSERT_NOW(a_q_sane, clk, rst_n, q_status.full, !q_status.empty && !push)

endmodule

>>> verif/sexpr_token_lexer_unit_tb.sv
// Self-checking testbench for the S-expression token lexer top level.
// Drives byte and end-of-stream transfers, predicts every token result and
// compares it field by field; depends on sxl_pkg and sexpr_token_lexer_unit.
module sexpr_token_lexer_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sxl_pkg::*;

    typedef struct {
        logic [7:0] ch;
        logic       eos;
        logic       drain;
    } src_item_t;

    typedef struct packed {
        logic        text_valid;
        logic [7:0]  text_byte;
        logic        token_done;
        logic [2:0]  token_kind;
        logic [30:0] integer_value;
        logic [1:0]  error_code;
        logic        last_of_run;
    } lex_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  next_byte = 8'h00;
    logic        end_of_stream = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        text_valid;
    logic [7:0]  text_byte;
    logic        token_done;
    logic [2:0]  token_kind;
    logic [30:0] integer_value;
    logic [1:0]  error_code;
    logic        last_of_run;

    src_item_t   src_queue[$];
    lex_result_t expected_tokens[$];
    mode_t       lex_mode = M_IDLE;
    logic [30:0] lex_acc = '0;
    logic        in_taken = 1'b0;
    int          accepted_cnt = 0;
    int          errors = 0;
    int          made_cnt = 0;
    bit          drain_next = 0;

    sexpr_token_lexer_unit uut (.*);

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        errors++;
        $display("%0t: %s: got %0h, want %0h", $realtime, what, got, want);
    endtask

    task check_field(string what, logic [31:0] got, logic [31:0] want);
        if (got !== want)
            report_mismatch(what, got, want);
    endtask

    function automatic bit is_ws(logic [7:0] c);
        return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic bit is_digit(logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function automatic lex_result_t mk(logic tv, logic [7:0] tb, logic done,
                                       logic [2:0] kind, logic [30:0] ival,
                                       logic [1:0] err);
        return '{tv, tb, done, kind, ival, err, 1'b0};
    endfunction

    function automatic lex_result_t finish_token();
        if (lex_mode == M_INT)
            return mk(1'b0, 8'h00, 1'b1, K_INT, lex_acc, E_NONE);
        else if (lex_mode == M_DBL)
            return mk(1'b0, 8'h00, 1'b1, K_DBL, '0, E_NONE);
        return mk(1'b0, 8'h00, 1'b1, K_IDENT, '0, E_NONE);
    endfunction

    task automatic lex_predict(logic [7:0] c, logic eos);
        lex_result_t run[$];
        logic        paren;
        logic [2:0]  pkind;
        logic [31:0] d;
        logic [31:0] acc32;
        logic [31:0] cap32;
        paren = (c == CH_LPAREN) || (c == CH_RPAREN);
        pkind = (c == CH_LPAREN) ? K_LPAR : K_RPAR;
        d     = {24'h0, c} - {24'h0, CH_ZERO};
        acc32 = {1'b0, lex_acc};
        cap32 = {1'b0, INT_CAP};
        if (eos)
        begin
            if (lex_mode inside {M_IDENT, M_INT, M_DBL})
                run.push_back(finish_token());
            else if (lex_mode inside {M_STR, M_HASH, M_CHR})
                run.push_back(mk(1'b0, 8'h00, 1'b0, K_IDENT, '0, E_UNTERM));
            lex_mode = M_IDLE;
            lex_acc  = '0;
        end
        else
        begin
            case (lex_mode)
                M_IDLE:
                begin
                    if (paren)
                    begin
                        run.push_back(mk(1'b0, 8'h00, 1'b1, pkind, '0, E_NONE));
                    end
                    else if (is_ws(c))
                    begin
                    end
                    else if (is_digit(c))
                    begin
                        run.push_back(mk(1'b1, c, 1'b0, K_IDENT, '0, E_NONE));
                        lex_acc  = d[30:0];
                        lex_mode = M_INT;
                    end
                    else if (c == CH_QUOTE)
                    begin
                        lex_mode = M_STR;
                    end
                    else if (c == CH_HASH)
                    begin
                        lex_mode = M_HASH;
                    end
                    else
                    begin
                        run.push_back(mk(1'b1, c, 1'b0, K_IDENT, '0, E_NONE));
                        lex_mode = M_IDENT;
                    end
                end
                M_IDENT, M_INT, M_DBL:
                begin
                    if (is_ws(c) || paren)
                    begin
                        run.push_back(finish_token());
                        if (paren)
                            run.push_back(mk(1'b0, 8'h00, 1'b1, pkind, '0, E_NONE));
                        lex_mode = M_IDLE;
                        lex_acc  = '0;
                    end
                    else
                    begin
                        run.push_back(mk(1'b1, c, 1'b0, K_IDENT, '0, E_NONE));
                        if (lex_mode == M_INT && is_digit(c))
                        begin
                            if (acc32 > (cap32 - d) / 10)
                                lex_acc = INT_CAP;
                            else
                                lex_acc = 31'(acc32 * 10 + d);
                        end
                        else if (lex_mode == M_INT && c == CH_DOT)
                        begin
                            lex_mode = M_DBL;
                            lex_acc  = '0;
                        end
                        else if (lex_mode == M_DBL && is_digit(c))
                        begin
                        end
                        else
                        begin
                            lex_mode = M_IDENT;
                            lex_acc  = '0;
                        end
                    end
                end
                M_STR:
                begin
                    if (c == CH_QUOTE)
                    begin
                        run.push_back(mk(1'b0, 8'h00, 1'b1, K_STR, '0, E_NONE));
                        lex_mode = M_IDLE;
                    end
                    else
                    begin
                        run.push_back(mk(1'b1, c, 1'b0, K_IDENT, '0, E_NONE));
                    end
                end
                M_HASH:
                begin
                    if (c == CH_BACKSLASH)
                    begin
                        lex_mode = M_CHR;
                    end
                    else
                    begin
                        run.push_back(mk(1'b0, 8'h00, 1'b0, K_IDENT, '0, E_BADHASH));
                        lex_mode = M_IDLE;
                    end
                end
                M_CHR:
                begin
                    run.push_back(mk(1'b1, c, 1'b1, K_CHR, '0, E_NONE));
                    lex_mode = M_IDLE;
                end
                default:
                begin
                    lex_mode = M_IDLE;
                    lex_acc  = '0;
                end
            endcase
        end
        if (run.size() > 0)
        begin
            run[run.size() - 1].last_of_run = 1'b1;
            foreach (run[i])
                expected_tokens.push_back(run[i]);
        end
    endtask

    function automatic int idle_len(inout int calm);
        int r;
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3)
            calm = $urandom_range(20, 80);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(11, 30);
    endfunction

    task automatic push_item(logic [7:0] c, logic eos);
        src_queue.push_back('{ch: c, eos: eos, drain: drain_next});
        drain_next = 0;
    endtask

    task automatic push_byte(logic [7:0] c);
        push_item(c, 1'b0);
        made_cnt++;
    endtask

    task automatic push_eos();
        push_item(8'($urandom_range(0, 255)), 1'b1);
        made_cnt++;
    endtask

    task automatic push_text(string s);
        for (int i = 0; i < s.len(); i++)
            push_byte(s[i]);
    endtask

    function automatic logic [7:0] rand_plain(bit first);
        logic [7:0] c;
        do
            c = 8'($urandom_range(0, 255));
        while (is_ws(c) || c == CH_LPAREN || c == CH_RPAREN ||
               (first && (is_digit(c) || c == CH_QUOTE || c == CH_HASH)));
        return c;
    endfunction

    function automatic logic [7:0] rand_ws();
        int r;
        r = $urandom_range(0, 5);
        return (r == 5) ? CH_SPACE : CH_TAB + 8'(r);
    endfunction

    function automatic logic [7:0] rand_digit();
        return CH_ZERO + 8'($urandom_range(0, 9));
    endfunction

    function automatic logic [7:0] rand_paren();
        return $urandom_range(0, 1) ? CH_LPAREN : CH_RPAREN;
    endfunction

    task automatic push_digits(int lo, int hi);
        int len;
        len = $urandom_range(lo, hi);
        for (int i = 0; i < len; i++)
            push_byte(rand_digit());
    endtask

    task automatic gen_token();
        int         r;
        int         len;
        logic [7:0] c;
        r = $urandom_range(0, 99);
        if (r < 18)
        begin
            len = $urandom_range(1, 6);
            push_byte(rand_plain(1));
            for (int i = 1; i < len; i++)
                push_byte(rand_plain(0));
        end
        else if (r < 38)
        begin
            if ($urandom_range(0, 9) == 0)
                push_digits(9, 12);
            else
                push_digits(1, 4);
        end
        else if (r < 48)
        begin
            push_digits(1, 3);
            push_byte(CH_DOT);
            push_digits(0, 3);
            if ($urandom_range(0, 4) == 0)
                push_byte(rand_plain(0));
        end
        else if (r < 58)
        begin
            push_byte(CH_QUOTE);
            len = $urandom_range(0, 6);
            for (int i = 0; i < len; i++)
            begin
                do
                    c = 8'($urandom_range(0, 255));
                while (c == CH_QUOTE);
                push_byte(c);
            end
            push_byte(CH_QUOTE);
        end
        else if (r < 66)
        begin
            push_byte(CH_HASH);
            push_byte(CH_BACKSLASH);
            push_byte(8'($urandom_range(0, 255)));
        end
        else if (r < 76)
        begin
            push_byte(rand_paren());
        end
        else if (r < 80)
        begin
            push_byte(CH_HASH);
            do
                c = 8'($urandom_range(0, 255));
            while (c == CH_BACKSLASH);
            push_byte(c);
        end
        else if (r < 85)
        begin
            case ($urandom_range(0, 2))
                0:
                begin
                    push_byte(CH_QUOTE);
                    push_byte(rand_plain(0));
                end
                1: push_byte(CH_HASH);
                default:
                begin
                    push_byte(CH_HASH);
                    push_byte(CH_BACKSLASH);
                end
            endcase
            push_eos();
        end
        else if (r < 92)
        begin
            push_digits(1, 3);
            do
                c = rand_plain(0);
            while (is_digit(c) || c == CH_DOT);
            push_byte(c);
        end
        else
        begin
            len = $urandom_range(1, 4);
            for (int i = 0; i < len; i++)
                push_byte(8'($urandom_range(0, 255)));
        end
        r = $urandom_range(0, 9);
        if (r < 5)
            push_byte(rand_ws());
        else if (r < 8)
            push_byte(rand_paren());
        else if (r == 8)
            push_eos();
    endtask

    always @(negedge clk)
    begin : drive_bytes
        src_item_t cur;
        int        gap_left;
        int        calm_left;
        if (rst_n)
        begin
            if (in_valid && !in_taken)
            begin
            end
            else if (gap_left > 0)
            begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (src_queue.size() != 0 &&
                     !(src_queue[0].drain && expected_tokens.size() != 0))
            begin
                cur = src_queue.pop_front();
                in_valid      <= 1'b1;
                next_byte     <= cur.ch;
                end_of_stream <= cur.eos;
                gap_left = idle_len(calm_left);
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(negedge clk)
    begin : drive_stall
        int stall_left;
        int hold_left;
        int out_calm;
        bit hold_done;
        if (rst_n)
        begin
            if (!hold_done && accepted_cnt >= 300)
            begin
                hold_done = 1;
                hold_left = 300;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                stall_left = idle_len(out_calm);
                out_stall <= (stall_left > 0);
                if (stall_left > 0)
                    stall_left--;
            end
        end
    end

    always @(posedge clk)
    begin : watch_ports
        lex_result_t want;
        if (rst_n)
        begin
            in_taken <= in_valid && !in_stall;
            if (out_valid && !out_stall)
            begin
                if (expected_tokens.size() == 0)
                begin
                    report_mismatch("unexpected output transfer", {24'h0, text_byte}, 0);
                end
                else
                begin
                    want = expected_tokens.pop_front();
                    check_field("text_valid", text_valid, want.text_valid);
                    check_field("text_byte", text_byte, want.text_byte);
                    check_field("token_done", token_done, want.token_done);
                    check_field("token_kind", token_kind, want.token_kind);
                    check_field("integer_value", integer_value, want.integer_value);
                    check_field("error_code", error_code, want.error_code);
                    check_field("last_of_run", last_of_run, want.last_of_run);
                end
            end
            if (in_valid && !in_stall)
            begin
                accepted_cnt++;
                lex_predict(next_byte, end_of_stream);
            end
        end
    end

    initial
    begin
        push_text("(9999999999)");
        push_text("1.5");
        push_eos();
        push_byte(CH_QUOTE);
        push_byte(8'hFF);
        push_byte(CH_QUOTE);
        push_text("#\\)");
        push_text("#x");
        push_byte(CH_QUOTE);
        push_eos();
        while (made_cnt < 520)
            gen_token();
        drain_next = 1;
        while (made_cnt < 1030)
            gen_token();

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (src_queue.size() != 0 || in_valid || expected_tokens.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (expected_tokens.size() != 0)
            report_mismatch("expected transfer never came", expected_tokens.size(), 0);
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
